[rtl/dmxrle_pkg.sv]
// ----------------------------------------------------------------------------
// dmxrle_pkg
// Shared types and constants of the run-length channel expander.
// ----------------------------------------------------------------------------
package dmxrle_pkg;

    localparam int DEF_MAX_CHANNELS    = 512;
    localparam int DEF_MAX_INPUT_BYTES = 512;
    localparam int DEF_LANES           = 8;

    // Lanes present on the result port and groups allowed per input beat.
    localparam int HW_LANES   = 8;
    localparam int MAX_GROUPS = 32;

    localparam logic [7:0] RUN_CODE = 8'hFE;
    localparam logic [7:0] ESC_CODE = 8'hFD;

    typedef enum logic [1:0] {
        PH_CODE  = 2'd0,
        PH_COUNT = 2'd1,
        PH_VALUE = 2'd2,
        PH_ESC   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
        logic       rle_mode;
    } in_item_t;

    typedef struct packed {
        logic [7:0] lane0_value;
        logic [7:0] lane1_value;
        logic [7:0] lane2_value;
        logic [7:0] lane3_value;
        logic [7:0] lane4_value;
        logic [7:0] lane5_value;
        logic [7:0] lane6_value;
        logic [7:0] lane7_value;
        logic [3:0] lanes_used;
        logic [8:0] first_channel;
        logic [8:0] source_offset;
        logic       group_last;
    } out_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic take_item;
        logic load_group;
    } ctl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic item_emits;
        logic last_group;
    } dp_status_t;

endpackage

[rtl/dmxrle_ctrl.sv]
// ----------------------------------------------------------------------------
// dmxrle_ctrl
// Sequencer: takes input beats and paces group emission into the output slot.
// ----------------------------------------------------------------------------
module dmxrle_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  dmxrle_pkg::dp_status_t status,
    output dmxrle_pkg::ctl_cmd_t   cmd
);
    import dmxrle_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cmd.take_item  = 1'b0;
        cmd.load_group = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take_item = 1'b1;
                    if (status.item_emits) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    cmd.load_group = 1'b1;
                    if (status.last_group) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_group) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/dmxrle_datapath.sv]
// ----------------------------------------------------------------------------
// dmxrle_datapath
// Decode state, run bookkeeping and the group output register.
// ----------------------------------------------------------------------------
module dmxrle_datapath #(
    parameter int MAX_CHANNELS    = dmxrle_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_INPUT_BYTES = dmxrle_pkg::DEF_MAX_INPUT_BYTES,
    parameter int LANES           = dmxrle_pkg::DEF_LANES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dmxrle_pkg::in_item_t   s_data,
    input  dmxrle_pkg::ctl_cmd_t   cmd,
    output dmxrle_pkg::dp_status_t status,
    output dmxrle_pkg::out_item_t  m_data
);
    import dmxrle_pkg::*;

    localparam int LANES_EFF = (LANES < 1) ? 1 : ((LANES > HW_LANES) ? HW_LANES : LANES);
    localparam int RUN_CAP   = MAX_GROUPS * LANES_EFF;
    localparam int CW_W      = $clog2(MAX_CHANNELS + 1);
    // An escape begun just below the limit may take two more bytes.
    localparam int BU_W      = $clog2(MAX_INPUT_BYTES + 3);

    phase_t          phase_reg, phase_next, phase_e;
    logic [CW_W-1:0] cw_reg, cw_next, cw_e, room;
    logic [BU_W-1:0] bu_reg, bu_next, bu_e;
    logic [7:0]      cnt_reg, cnt_next;
    logic [8:0]      co_reg, co_next;
    logic [7:0]      rem_reg, rem_next;
    logic [7:0]      val_reg, val_next;
    logic [8:0]      off_reg, off_next;
    out_item_t       out_reg, out_next;

    logic            open_ok, emit;
    logic [7:0]      n_req, n_fin;
    logic [11:0]     n_lim;
    logic [8:0]      off_sel;
    logic [3:0]      k;
    logic [7:0]      lane_val [HW_LANES];

    // Decode of the incoming beat.
    always_comb begin
        phase_e = s_data.packet_start ? PH_CODE : phase_reg;
        cw_e    = s_data.packet_start ? '0 : cw_reg;
        bu_e    = s_data.packet_start ? '0 : bu_reg;
        open_ok = (bu_e < BU_W'(MAX_INPUT_BYTES)) && (cw_e < CW_W'(MAX_CHANNELS));

        phase_next = phase_e;
        bu_next    = bu_e;
        cnt_next   = cnt_reg;
        co_next    = co_reg;
        emit       = 1'b0;
        n_req      = 8'd1;
        off_sel    = 9'(bu_e);

        if (!s_data.rle_mode) begin
            phase_next = PH_CODE;
            if (open_ok) begin
                bu_next = bu_e + BU_W'(1);
                emit    = 1'b1;
            end
        end else begin
            case (phase_e)
                PH_COUNT: begin
                    bu_next    = bu_e + BU_W'(1);
                    cnt_next   = s_data.data_byte;
                    phase_next = PH_VALUE;
                end
                PH_VALUE: begin
                    bu_next    = bu_e + BU_W'(1);
                    phase_next = PH_CODE;
                    emit       = 1'b1;
                    n_req      = cnt_reg;
                    off_sel    = co_reg;
                end
                PH_ESC: begin
                    bu_next    = bu_e + BU_W'(1);
                    phase_next = PH_CODE;
                    emit       = 1'b1;
                end
                default: begin
                    if (open_ok) begin
                        bu_next = bu_e + BU_W'(1);
                        if (s_data.data_byte == RUN_CODE) begin
                            co_next    = 9'(bu_e);
                            phase_next = PH_COUNT;
                        end else if (s_data.data_byte == ESC_CODE) begin
                            phase_next = PH_ESC;
                        end else begin
                            emit = 1'b1;
                        end
                    end
                end
            endcase
        end

        // Clip the run to the channels left and to the group budget.
        room  = CW_W'(MAX_CHANNELS) - cw_e;
        n_lim = (12'(room) < 12'(n_req)) ? 12'(room) : 12'(n_req);
        if (12'(RUN_CAP) < n_lim) begin
            n_lim = 12'(RUN_CAP);
        end
        n_fin = 8'(n_lim);
    end

    assign status.item_emits = emit && (n_fin != 8'd0);
    assign status.last_group = (rem_reg <= 8'(LANES_EFF));

    // Next group.
    assign k = (rem_reg < 8'(LANES_EFF)) ? 4'(rem_reg) : 4'(LANES_EFF);

    always_comb begin
        for (int j = 0; j < HW_LANES; j++) begin
            lane_val[j] = (4'(j) < k) ? val_reg : 8'd0;
        end
        out_next               = out_reg;
        out_next.lane0_value   = lane_val[0];
        out_next.lane1_value   = lane_val[1];
        out_next.lane2_value   = lane_val[2];
        out_next.lane3_value   = lane_val[3];
        out_next.lane4_value   = lane_val[4];
        out_next.lane5_value   = lane_val[5];
        out_next.lane6_value   = lane_val[6];
        out_next.lane7_value   = lane_val[7];
        out_next.lanes_used    = k;
        out_next.first_channel = 9'(cw_reg);
        out_next.source_offset = off_reg;
        out_next.group_last    = status.last_group;
    end

    always_comb begin
        cw_next  = cw_reg;
        rem_next = rem_reg;
        val_next = val_reg;
        off_next = off_reg;
        if (cmd.take_item) begin
            cw_next  = cw_e;
            rem_next = n_fin;
            val_next = s_data.data_byte;
            off_next = off_sel;
        end else if (cmd.load_group) begin
            cw_next  = cw_reg + CW_W'(k);
            rem_next = rem_reg - 8'(k);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CODE;
            cw_reg    <= '0;
            bu_reg    <= '0;
            rem_reg   <= '0;
        end else begin
            if (cmd.take_item) begin
                phase_reg <= phase_next;
                bu_reg    <= bu_next;
            end
            cw_reg  <= cw_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            cnt_reg <= cnt_next;
            co_reg  <= co_next;
        end
        val_reg <= val_next;
        off_reg <= off_next;
        if (cmd.load_group) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

[rtl/dmx_rle_channel_expander_top.sv]
// ----------------------------------------------------------------------------
// dmx_rle_channel_expander_top
// Run-length channel expander: payload bytes in, groups of channel values out.
// ----------------------------------------------------------------------------
// Flow: a byte that makes channels moves the sequencer to its emit state on
//   acceptance; its groups then load into the output slot in order.
// A byte that makes no group leaves the block idle; a new byte is taken only
//   once the last group of the one before has loaded (one group a cycle while the slot is free).
// Reset: aresetn (synchronous, active low) returns the decoder to "expect new
//   code" with zero channel and byte counts and empties the output slot.
// ----------------------------------------------------------------------------
module dmx_rle_channel_expander_top #(
    parameter int MAX_CHANNELS    = dmxrle_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_INPUT_BYTES = dmxrle_pkg::DEF_MAX_INPUT_BYTES,
    parameter int LANES           = dmxrle_pkg::DEF_LANES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input beats: one payload byte each
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dmxrle_pkg::in_item_t  s_data,
    // Result beats: one channel group each
    output logic                  m_valid,
    input  logic                  m_ready,
    output dmxrle_pkg::out_item_t m_data
);
    import dmxrle_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    // Sequencer: take a beat when idle, then drain its groups into the slot.
    dmxrle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: escape decode, limit checks, run counter, output register.
    dmxrle_datapath #(
        .MAX_CHANNELS    (MAX_CHANNELS),
        .MAX_INPUT_BYTES (MAX_INPUT_BYTES),
        .LANES           (LANES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

endmodule

[dv/dmx_rle_channel_expander_top_tb.sv]
// ----------------------------------------------------------------------------
// dmx_rle_channel_expander_top_tb
// Self-checking bench for the run-length channel expander: a directed table
// of payload beats, then random raw and run-length packets under three idle
// profiles. Every accepted byte is run through a local decoder model and the
// channel groups it yields are compared field by field, in order, with the
// groups the block sends.
// ----------------------------------------------------------------------------
module dmx_rle_channel_expander_top_tb;

    import dmxrle_pkg::*;

    localparam int MAX_CH   = DEF_MAX_CHANNELS;
    localparam int MAX_IN   = DEF_MAX_INPUT_BYTES;
    localparam int LANE_CNT = (DEF_LANES < 1) ? 1 :
                              ((DEF_LANES > HW_LANES) ? HW_LANES : DEF_LANES);

    // Worst byte makes MAX_GROUPS groups; allow a margin for the drain.
    localparam int DRAIN_CYCLES = MAX_GROUPS + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_BEATS  = 100;
    localparam int MAX_PRINTS   = 40;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    dmx_rle_channel_expander_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------------
    // Clock and cycle count
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    int cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // Decoder model: its own copy of phase, counts and the pending run offset
    // ------------------------------------------------------------------------
    phase_t     dec_phase;
    logic [7:0] run_len;
    int         chans_done;
    int         bytes_taken;
    int         run_offset;

    out_item_t  fresh_groups[$];    // groups made by the byte just taken
    out_item_t  pending_groups[$];  // groups still owed by the block

    // Hard stop: a hung handshake ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("Timeout after %0d cycles, %0d groups still expected",
                 cycle_count, pending_groups.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void clear_decoder();
        dec_phase   = PH_CODE;
        run_len     = 8'h00;
        chans_done  = 0;
        bytes_taken = 0;
        run_offset  = 0;
    endfunction

    // Split n channels of one value into lane groups, clipped to the channel
    // limit and to the group budget of a single byte.
    function automatic void emit_run(logic [7:0] value, int n, int offset);
        int        room;
        int        k;
        out_item_t g;
        room = (chans_done < MAX_CH) ? MAX_CH - chans_done : 0;
        if (n > room)
            n = room;
        if (n > MAX_GROUPS * LANE_CNT)
            n = MAX_GROUPS * LANE_CNT;
        while (n > 0) begin
            k = (n < LANE_CNT) ? n : LANE_CNT;
            g = '0;
            g.lane0_value   = value;
            g.lane1_value   = (k > 1) ? value : 8'h00;
            g.lane2_value   = (k > 2) ? value : 8'h00;
            g.lane3_value   = (k > 3) ? value : 8'h00;
            g.lane4_value   = (k > 4) ? value : 8'h00;
            g.lane5_value   = (k > 5) ? value : 8'h00;
            g.lane6_value   = (k > 6) ? value : 8'h00;
            g.lane7_value   = (k > 7) ? value : 8'h00;
            g.lanes_used    = 4'(k);
            g.first_channel = 9'(chans_done);
            g.source_offset = 9'(offset);
            chans_done += k;
            n -= k;
            g.group_last = (n == 0);
            fresh_groups.push_back(g);
        end
    endfunction

    function automatic void expand_byte(in_item_t it);
        bit is_open;
        int here;
        fresh_groups.delete();
        if (it.packet_start)
            clear_decoder();
        is_open = (bytes_taken < MAX_IN) && (chans_done < MAX_CH);
        here    = bytes_taken;

        // Raw mode also abandons any escape left open.
        if (!it.rle_mode) begin
            dec_phase = PH_CODE;
            if (is_open) begin
                bytes_taken++;
                emit_run(it.data_byte, 1, here);
            end
            return;
        end

        case (dec_phase)
            PH_COUNT: begin
                bytes_taken++;
                run_len   = it.data_byte;
                dec_phase = PH_VALUE;
            end
            PH_VALUE: begin
                bytes_taken++;
                dec_phase = PH_CODE;
                emit_run(it.data_byte, int'(run_len), run_offset);
            end
            PH_ESC: begin
                bytes_taken++;
                dec_phase = PH_CODE;
                emit_run(it.data_byte, 1, here);
            end
            default: begin
                if (is_open) begin
                    bytes_taken++;
                    if (it.data_byte == RUN_CODE) begin
                        run_offset = here;
                        dec_phase  = PH_COUNT;
                    end else if (it.data_byte == ESC_CODE) begin
                        dec_phase = PH_ESC;
                    end else begin
                        emit_run(it.data_byte, 1, here);
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------------
    int mismatches     = 0;
    int groups_checked = 0;

    task automatic report_mismatch(string what);
        if (mismatches < MAX_PRINTS)
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic match_field(string name, int got, int want, int idx);
        if (got != want)
            report_mismatch($sformatf("group %0d %s got 0x%0h want 0x%0h",
                                      idx, name, got, want));
    endtask

    // Take every result beat at the edge where it moves; compare with the
    // oldest group owed.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_groups.size() == 0) begin
                report_mismatch($sformatf("unexpected group, channel %0d",
                                          m_data.first_channel));
            end else begin
                want = pending_groups.pop_front();
                match_field("lane0", m_data.lane0_value, want.lane0_value, groups_checked);
                match_field("lane1", m_data.lane1_value, want.lane1_value, groups_checked);
                match_field("lane2", m_data.lane2_value, want.lane2_value, groups_checked);
                match_field("lane3", m_data.lane3_value, want.lane3_value, groups_checked);
                match_field("lane4", m_data.lane4_value, want.lane4_value, groups_checked);
                match_field("lane5", m_data.lane5_value, want.lane5_value, groups_checked);
                match_field("lane6", m_data.lane6_value, want.lane6_value, groups_checked);
                match_field("lane7", m_data.lane7_value, want.lane7_value, groups_checked);
                match_field("lanes_used", m_data.lanes_used, want.lanes_used,
                            groups_checked);
                match_field("first_channel", m_data.first_channel, want.first_channel,
                            groups_checked);
                match_field("source_offset", m_data.source_offset, want.source_offset,
                            groups_checked);
                match_field("group_last", m_data.group_last, want.group_last,
                            groups_checked);
            end
            groups_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, plus one long hold-off counted here
    // ------------------------------------------------------------------------
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_armed   = 1'b0;   // written by the stimulus only

    initial begin
        bit hold_taken;
        int hold_left;
        hold_taken = 1'b0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_armed && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                // Hold off so the output slot fills and s_ready drops.
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    int beats_sent   = 0;
    int packets_sent = 0;

    // Offer one beat after a random gap; hold it until it moves, then queue
    // the groups it should make (the typed group for table rows that have one).
    task automatic send_byte(in_item_t it, bit typed, out_item_t want);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        expand_byte(it);
        if (typed)
            pending_groups.push_back(want);
        else
            foreach (fresh_groups[i]) pending_groups.push_back(fresh_groups[i]);
        beats_sent++;
        if (it.packet_start)
            packets_sent++;
    endtask

    task automatic put(logic [7:0] b, bit start, bit rle);
        in_item_t it;
        it.data_byte    = b;
        it.packet_start = start;
        it.rle_mode     = rle;
        send_byte(it, 1'b0, '0);
    endtask

    // Drop valid, wait for every owed group, then let the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_groups.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] plain_literal();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == RUN_CODE || b == ESC_CODE)
            b = 8'($urandom_range(0, 252));
        return b;
    endfunction

    // Long runs that cross the channel limit; codes after it are dropped.
    task automatic flood_packet();
        put(plain_literal(), 1'b1, 1'b1);
        repeat (4) begin
            put(RUN_CODE, 1'b0, 1'b1);
            put(8'($urandom_range(150, 255)), 1'b0, 1'b1);
            put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            if ($urandom_range(0, 1)) begin
                put(ESC_CODE, 1'b0, 1'b1);
                put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end else begin
                put(plain_literal(), 1'b0, 1'b1);
            end
        end
    endtask

    // Mostly well-formed packets with random content; some noise and
    // escapes left cut off by the next packet.
    task automatic random_packet();
        int kind;
        int codes;
        int r;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            flood_packet();
        end else if (kind <= 2) begin
            put(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            repeat ($urandom_range(0, 30)) put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end else begin
            codes = $urandom_range(2, 12);
            put(plain_literal(), 1'b1, 1'b1);
            repeat (codes) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    put(plain_literal(), 1'b0, 1'b1);
                end else if (r < 70) begin
                    put(RUN_CODE, 1'b0, 1'b1);
                    if ($urandom_range(0, 9) == 0)
                        put(8'($urandom_range(100, 255)), 1'b0, 1'b1);
                    else
                        put(8'($urandom_range(0, 24)), 1'b0, 1'b1);
                    put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                end else if (r < 88) begin
                    put(ESC_CODE, 1'b0, 1'b1);
                    put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                end else if (r < 94) begin
                    // Mode flips to raw inside a packet.
                    put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end else begin
                    // Escape broken by a raw byte.
                    put($urandom_range(0, 1) ? RUN_CODE : ESC_CODE, 1'b0, 1'b1);
                    put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
            end
            // Leave an escape open for the next packet to discard.
            if ($urandom_range(0, 6) == 0) begin
                put($urandom_range(0, 1) ? RUN_CODE : ESC_CODE, 1'b0, 1'b1);
                if ($urandom_range(0, 1))
                    put(8'($urandom_range(1, 20)), 1'b0, 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    task automatic add_row(logic [7:0] b, bit start, bit rle, bit typed, out_item_t want);
        dir_row_t row;
        row.item.data_byte    = b;
        row.item.packet_start = start;
        row.item.rle_mode     = rle;
        row.typed             = typed;
        row.want              = want;
        dir_rows.push_back(row);
    endtask

    function automatic out_item_t one_lane(logic [7:0] v, int ch, int off);
        out_item_t g;
        g = '0;
        g.lane0_value   = v;
        g.lanes_used    = 4'd1;
        g.first_channel = 9'(ch);
        g.source_offset = 9'(off);
        g.group_last    = 1'b1;
        return g;
    endfunction

    task automatic build_table();
        // Raw extremes after reset; the run code is plain data in raw mode.
        add_row(8'h00, 1'b1, 1'b0, 1'b1, one_lane(8'h00, 0, 0));
        add_row(8'hFF, 1'b0, 1'b0, 1'b1, one_lane(8'hFF, 1, 1));
        add_row(RUN_CODE, 1'b0, 1'b0, 1'b1, one_lane(RUN_CODE, 2, 2));
        // Run-length packet: literal, run of 20, zero-count run.
        add_row(8'h41, 1'b1, 1'b1, 1'b1, one_lane(8'h41, 0, 0));
        add_row(RUN_CODE, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'd20, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'hAA, 1'b0, 1'b1, 1'b0, '0);
        add_row(RUN_CODE, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h55, 1'b0, 1'b1, 1'b0, '0);
        // Escaped run code and escaped escape code.
        add_row(ESC_CODE, 1'b0, 1'b1, 1'b0, '0);
        add_row(RUN_CODE, 1'b0, 1'b1, 1'b0, '0);
        add_row(ESC_CODE, 1'b0, 1'b1, 1'b0, '0);
        add_row(ESC_CODE, 1'b0, 1'b1, 1'b0, '0);
        // Longest run: 255 channels, the full group budget of one byte.
        add_row(RUN_CODE, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);
        // Escape abandoned by a raw byte.
        add_row(ESC_CODE, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h12, 1'b0, 1'b0, 1'b0, '0);
        // Run cut off by a new packet.
        add_row(RUN_CODE, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h07, 1'b1, 1'b1, 1'b1, one_lane(8'h07, 0, 0));
        add_row(RUN_CODE, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h33, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h80, 1'b1, 1'b0, 1'b1, one_lane(8'h80, 0, 0));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int mark;
        clear_decoder();
        build_table();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender mostly busy, receiver mostly stalled.
        src_idle_pct = 8;
        snk_idle_pct = 62;
        foreach (dir_rows[i]) send_byte(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        drain();

        mark = beats_sent;
        while (beats_sent - mark < PHASE_BEATS) random_packet();
        drain();

        // Sender sparse, receiver eager.
        src_idle_pct = 62;
        snk_idle_pct = 8;
        mark = beats_sent;
        while (beats_sent - mark < PHASE_BEATS) random_packet();
        drain();

        // No idling: long hold-off under a flood, then random packets.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_armed   = 1'b1;
        flood_packet();
        drain();
        mark = beats_sent;
        while (beats_sent - mark < PHASE_BEATS) random_packet();
        drain();

        $display("Run covered %0d payload beats in %0d packets, %0d channel groups checked,",
                 beats_sent, packets_sent, groups_checked);
        $display("raw and run-length modes, escapes, the channel limit and a long output stall");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
